// ===== src/bcc_pkg.sv =====
// ---------------------------------------------------------------------------
// bcc_pkg
// Shared types and codes for the button click classifier.
// ---------------------------------------------------------------------------
package bcc_pkg;

  localparam logic [1:0] KIND_EDGE  = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_SINGLE = 2'd1;
  localparam logic [1:0] EV_DOUBLE = 2'd2;
  localparam logic [1:0] EV_HOLD   = 2'd3;

  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_DOUBLE   = 1'b1;

  typedef struct packed {
    logic [1:0]  pending;
    logic        press_flag;
    logic        double_wait;
    logic        hold_wait;
    logic [31:0] press_time;
  } bcc_entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        released;
    logic [31:0] now_ms;
    logic [15:0] double_click_ms;
  } bcc_op_t;

endpackage

// ===== src/bcc_state_store.sv =====
// ---------------------------------------------------------------------------
// bcc_state_store
// Per-button state memory, registered read, valid bit per entry
// so that reset and clear-all make every entry read as zero.
// ---------------------------------------------------------------------------
module bcc_state_store #(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clear,
  input  logic [AW-1:0]          rd_addr,
  output bcc_pkg::bcc_entry_t    rd_data,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  bcc_pkg::bcc_entry_t    wr_data
);
  import bcc_pkg::*;

  bcc_entry_t       mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  bcc_entry_t       rd_raw_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (clear) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_raw_r : '0;

endmodule

// ===== src/bcc_rules.sv =====
// ---------------------------------------------------------------------------
// bcc_rules
// Update rules for one button entry: press edge, tick classification and
// query-and-consume.
// ---------------------------------------------------------------------------
module bcc_rules (
  input  bcc_pkg::bcc_op_t    op,
  input  bcc_pkg::bcc_entry_t ent_in,
  output bcc_pkg::bcc_entry_t ent_out,
  output logic [1:0]          res
);
  import bcc_pkg::*;

  logic [31:0] elapsed;
  logic        late;

  assign elapsed = op.now_ms - ent_in.press_time;
  assign late    = elapsed > {16'd0, op.double_click_ms};

  always_comb begin
    ent_out = ent_in;
    res     = EV_NONE;
    case (op.kind)
      KIND_EDGE: begin
        ent_out.press_flag = 1'b1;
      end
      KIND_TICK: begin
        if (ent_in.pending == EV_NONE) begin
          if (!ent_in.hold_wait && !ent_in.double_wait && ent_in.press_flag) begin
            ent_out.double_wait = 1'b1;
            ent_out.hold_wait   = 1'b1;
            ent_out.press_time  = op.now_ms;
            ent_out.press_flag  = 1'b0;
          end else if (ent_in.double_wait && ent_in.press_flag &&
                       !ent_in.hold_wait && !late) begin
            ent_out.double_wait = 1'b0;
            ent_out.press_flag  = 1'b0;
            ent_out.pending     = EV_DOUBLE;
          end else if (!ent_in.hold_wait && ent_in.double_wait && late) begin
            ent_out.double_wait = 1'b0;
            ent_out.press_flag  = 1'b0;
            ent_out.pending     = EV_SINGLE;
          end else if (ent_in.hold_wait && late) begin
            ent_out.double_wait = 1'b0;
            ent_out.press_flag  = 1'b0;
            ent_out.pending     = EV_HOLD;
          end
          if (op.released) begin
            ent_out.hold_wait = 1'b0;
          end
        end
      end
      KIND_QUERY: begin
        res = ent_in.pending;
        if (ent_in.pending == EV_HOLD) begin
          ent_out.pending     = EV_NONE;
          ent_out.press_flag  = 1'b0;
          ent_out.double_wait = 1'b0;
        end else if (ent_in.pending != EV_NONE) begin
          ent_out = '0;
        end
      end
      default: begin
        ent_out = ent_in;
      end
    endcase
  end

endmodule

// ===== src/button_click_classifier_core.sv =====
// ---------------------------------------------------------------------------
// button_click_classifier_core
// Single, double and hold click classifier for a set of buttons.
// ---------------------------------------------------------------------------
// Each input item is one of four kinds (tuser): press edge, timer tick,
// query, clear all. Every item returns exactly one result item whose
// event_res is the query answer (zero for the other kinds). Button state
// sits in a small memory with a registered read; the sequencer reads an
// entry, applies the rules and writes it back. An edge or query item passes
// through the read, modify and done states; a tick visits every button in
// turn through read and modify; a clear or a debounced edge goes straight
// to done. One item is processed at a time; a new item is taken while the
// previous result still waits at the output register.
// ---------------------------------------------------------------------------
module button_click_classifier_core #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // button[1:0], now_ms[33:2], released_mask[37:34]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // event_res[1:0]
);
  import bcc_pkg::*;

  localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [15:0]   debounce_r, double_r;
  logic [31:0]   last_edge_r;
  logic [1:0]    kind_r;
  logic [31:0]   now_r;
  logic [3:0]    rel_r;
  logic [BW-1:0] idx_r, idx_nxt;
  logic [1:0]    res_r;
  logic          out_vld_r;
  logic [1:0]    out_ev_r;

  logic          in_acc;
  logic [1:0]    i_button;
  logic [31:0]   i_now;
  logic [3:0]    i_rel;
  logic          edge_pass;
  logic          btn_ok;
  logic          clear_all;
  logic          rel_bit;
  logic          wr_en;
  logic          last_btn;

  bcc_op_t       op;
  bcc_entry_t    rd_ent, wr_ent;
  logic [1:0]    rule_res;

  assign i_button  = in_tdata[1:0];
  assign i_now     = in_tdata[33:2];
  assign i_rel     = in_tdata[37:34];

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign edge_pass = (i_now - last_edge_r) > {16'd0, debounce_r};
  assign btn_ok    = int'(i_button) < NUM_BUTTONS;
  assign clear_all = in_acc && (in_tuser == KIND_CLEAR);
  assign last_btn  = int'(idx_r) == NUM_BUTTONS - 1;
  assign wr_en     = (state_r == ST_MOD);

  always_comb begin
    rel_bit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (int'(idx_r) == i) begin
        rel_bit = rel_r[i];
      end
    end
  end

  assign op.kind            = kind_r;
  assign op.released        = rel_bit;
  assign op.now_ms          = now_r;
  assign op.double_click_ms = double_r;

  bcc_state_store #(
    .DEPTH (NUM_BUTTONS),
    .AW    (BW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (clear_all),
    .rd_addr (idx_r),
    .rd_data (rd_ent),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_ent)
  );

  bcc_rules u_rules (
    .op      (op),
    .ent_in  (rd_ent),
    .ent_out (wr_ent),
    .res     (rule_res)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt = BW'(i_button);
          case (in_tuser)
            KIND_EDGE:  state_nxt = (edge_pass && btn_ok) ? ST_RD : ST_DONE;
            KIND_TICK: begin
              idx_nxt   = '0;
              state_nxt = ST_RD;
            end
            KIND_QUERY: state_nxt = btn_ok ? ST_RD : ST_DONE;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_RD: begin
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (kind_r == KIND_TICK && !last_btn) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      default: begin
        if (!out_vld_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      debounce_r  <= 16'd50;
      double_r    <= 16'd300;
      last_edge_r <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DEBOUNCE) begin
          debounce_r <= cfg_data;
        end else begin
          double_r <= cfg_data;
        end
      end
      if (in_acc && in_tuser == KIND_EDGE && edge_pass) begin
        last_edge_r <= i_now;
      end
      if (state_r == ST_DONE && (!out_vld_r || out_tready)) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (in_acc) begin
      kind_r <= in_tuser;
      now_r  <= i_now;
      rel_r  <= i_rel;
      res_r  <= EV_NONE;
    end else if (state_r == ST_MOD) begin
      res_r <= rule_res;
    end
    if (state_r == ST_DONE && (!out_vld_r || out_tready)) begin
      out_ev_r <= res_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_ev_r};

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for button_click_classifier_core.
// ---------------------------------------------------------------------------
// Items go in through the input stream with random gaps, and results are
// drawn with random stalls and one long hold-off. The bench keeps its own
// copy of every button's state and predicts each item's event code. Each
// result is matched in order against those predictions. Directed tests
// cover single, double and hold clicks, the debounce check, a busy button
// skipped on a tick, clear all and the register extremes. Random phases
// under several settings then play mostly well-formed click sequences
// mixed with noise items.
// ---------------------------------------------------------------------------
module tb;
  import bcc_pkg::*;

  localparam int NUM_BTN         = 4;
  localparam int HOLD_OFF_CYCLES = 120;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // button[1:0], now_ms[33:2], released_mask[37:34]
  logic [1:0]  in_tuser;   // kind[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // event_res[1:0]

  button_click_classifier_core #(
    .NUM_BUTTONS(NUM_BTN)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // predicted button state
  logic [15:0] debounce_cfg;
  logic [15:0] window_cfg;
  logic [1:0]  btn_event     [NUM_BTN];
  logic        btn_pressed   [NUM_BTN];
  logic        btn_dbl_wait  [NUM_BTN];
  logic        btn_hold_wait [NUM_BTN];
  logic [31:0] btn_press_ms  [NUM_BTN];
  logic [31:0] last_edge_ms;

  logic [1:0]  expected_events[$];
  int          error_count;
  int          items_sent;
  bit          idle_on;
  bit          hold_off_req;
  int          stall_left;
  logic [31:0] sim_ms;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic void clear_buttons();
    for (int b = 0; b < NUM_BTN; b++) begin
      btn_event[b]     = EV_NONE;
      btn_pressed[b]   = 1'b0;
      btn_dbl_wait[b]  = 1'b0;
      btn_hold_wait[b] = 1'b0;
      btn_press_ms[b]  = '0;
    end
  endfunction

  function automatic logic [1:0] predict_event(input logic [1:0] kind,
                                               input logic [1:0] button,
                                               input logic [31:0] now_ms,
                                               input logic [3:0] rel_mask);
    logic [1:0]  answer;
    logic [31:0] since_ms;
    logic        late;
    answer = EV_NONE;
    case (kind)
      KIND_EDGE: begin
        since_ms = now_ms - last_edge_ms;
        if (since_ms > {16'd0, debounce_cfg}) begin
          btn_pressed[button] = 1'b1;
          last_edge_ms        = now_ms;
        end
      end
      KIND_TICK: begin
        for (int b = 0; b < NUM_BTN; b++) begin
          if (btn_event[b] == EV_NONE) begin
            since_ms = now_ms - btn_press_ms[b];
            late     = since_ms > {16'd0, window_cfg};
            if (!btn_hold_wait[b] && !btn_dbl_wait[b] && btn_pressed[b]) begin
              btn_dbl_wait[b]  = 1'b1;
              btn_hold_wait[b] = 1'b1;
              btn_press_ms[b]  = now_ms;
              btn_pressed[b]   = 1'b0;
            end else if (btn_dbl_wait[b] && btn_pressed[b] && !btn_hold_wait[b] && !late) begin
              btn_dbl_wait[b] = 1'b0;
              btn_pressed[b]  = 1'b0;
              btn_event[b]    = EV_DOUBLE;
            end else if (!btn_hold_wait[b] && btn_dbl_wait[b] && late) begin
              btn_dbl_wait[b] = 1'b0;
              btn_pressed[b]  = 1'b0;
              btn_event[b]    = EV_SINGLE;
            end else if (btn_hold_wait[b] && late) begin
              btn_dbl_wait[b] = 1'b0;
              btn_pressed[b]  = 1'b0;
              btn_event[b]    = EV_HOLD;
            end
            if (rel_mask[b]) btn_hold_wait[b] = 1'b0;
          end
        end
      end
      KIND_QUERY: begin
        answer = btn_event[button];
        if (answer != EV_NONE) begin
          btn_event[button]    = EV_NONE;
          btn_pressed[button]  = 1'b0;
          btn_dbl_wait[button] = 1'b0;
          // a consumed hold keeps waiting for the release
          if (answer != EV_HOLD) begin
            btn_hold_wait[button] = 1'b0;
            btn_press_ms[button]  = '0;
          end
        end
      end
      default: clear_buttons();
    endcase
    return answer;
  endfunction

  // result side: random stalls and an on-demand long hold-off
  initial begin
    out_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (hold_off_req) begin
        out_tready   = 1'b0;
        stall_left   = HOLD_OFF_CYCLES - 1;
        hold_off_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_events.size() == 0) begin
        $error("unexpected result item, event_res %0d", out_tdata[1:0]);
        error_count++;
      end else begin
        if (out_tdata[1:0] !== expected_events[0]) begin
          $error("event_res mismatch: expected %0d, actual %0d",
                 expected_events[0], out_tdata[1:0]);
          error_count++;
        end
        void'(expected_events.pop_front());
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_item(input logic [1:0] kind, input logic [1:0] button,
                           input logic [31:0] now_ms, input logic [3:0] rel_mask);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap       = $urandom_range(1, 5);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {2'b00, rel_mask, now_ms, button};
    do @(posedge clk); while (!in_tready);
    expected_events.push_back(predict_event(kind, button, now_ms, rel_mask));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] value);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_DEBOUNCE) debounce_cfg = value;
    else window_cfg = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_click_kinds();
    logic [31:0] t0;
    t0 = 32'hFFFF_FF00;
    send_item(KIND_QUERY, 2'd0, t0, 4'h0);
    // single on button 0, crossing the 32-bit wrap
    send_item(KIND_EDGE,  2'd0, t0 + 100, 4'h0);
    send_item(KIND_EDGE,  2'd1, t0 + 120, 4'h0);    // too soon, debounced
    send_item(KIND_TICK,  2'd0, t0 + 110, 4'b0001);
    send_item(KIND_TICK,  2'd0, t0 + 411, 4'h0);
    // double on button 2 while button 0 is busy
    send_item(KIND_EDGE,  2'd2, t0 + 500, 4'h0);
    send_item(KIND_TICK,  2'd3, t0 + 505, 4'hF);
    send_item(KIND_EDGE,  2'd2, t0 + 600, 4'h0);
    send_item(KIND_TICK,  2'd0, t0 + 610, 4'h0);
    send_item(KIND_QUERY, 2'd0, t0 + 620, 4'h0);
    send_item(KIND_QUERY, 2'd2, t0 + 621, 4'h0);
    send_item(KIND_QUERY, 2'd1, t0 + 622, 4'h0);
    // hold on button 3, reported again after the query
    send_item(KIND_EDGE,  2'd3, t0 + 700, 4'h0);
    send_item(KIND_TICK,  2'd0, t0 + 701, 4'h0);
    send_item(KIND_TICK,  2'd0, t0 + 1002, 4'h0);
    send_item(KIND_QUERY, 2'd3, t0 + 1003, 4'h0);
    send_item(KIND_TICK,  2'd0, t0 + 1010, 4'b1000);
    send_item(KIND_QUERY, 2'd3, t0 + 1011, 4'h0);
    // clear all drops a latched press
    send_item(KIND_EDGE,  2'd1, t0 + 1100, 4'h0);
    send_item(KIND_CLEAR, 2'd3, t0 + 1101, 4'hF);
    send_item(KIND_TICK,  2'd1, t0 + 1110, 4'h0);
    send_item(KIND_QUERY, 2'd1, t0 + 1500, 4'h0);
    sim_ms = t0 + 2000;
  endtask

  task automatic test_register_extremes();
    logic [31:0] t;
    t = 32'h8000_0000;
    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_DOUBLE, 16'd0);
    send_item(KIND_EDGE,  2'd0, t, 4'h0);
    send_item(KIND_EDGE,  2'd1, t, 4'h0);           // zero gap is not enough
    send_item(KIND_TICK,  2'd0, t, 4'hF);
    send_item(KIND_TICK,  2'd0, t, 4'h0);
    send_item(KIND_TICK,  2'd0, t + 1, 4'h0);
    send_item(KIND_QUERY, 2'd0, t + 1, 4'h0);
    send_item(KIND_QUERY, 2'd1, t + 1, 4'h0);
    write_reg(CFG_DEBOUNCE, 16'hFFFF);
    write_reg(CFG_DOUBLE, 16'hFFFF);
    t = t + 70000;
    send_item(KIND_EDGE,  2'd2, t, 4'h0);
    send_item(KIND_EDGE,  2'd3, t + 65535, 4'h0);   // exactly at the limit
    send_item(KIND_TICK,  2'd0, t + 65535, 4'h0);
    send_item(KIND_TICK,  2'd0, t + 2 * 65535, 4'h0);
    send_item(KIND_TICK,  2'd0, t + 2 * 65535 + 1, 4'hF);
    send_item(KIND_QUERY, 2'd2, t + 2 * 65535 + 2, 4'h0);
    send_item(KIND_QUERY, 2'd3, t + 2 * 65535 + 2, 4'h0);
    sim_ms = t + 200000;
  endtask

  task automatic click_sequence();
    logic [1:0] b;
    logic [3:0] rel;
    int         pick;
    b    = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 4);
    sim_ms += debounce_cfg + 1 + $urandom_range(0, 20);
    send_item(KIND_EDGE, b, sim_ms, 4'($urandom));
    sim_ms += $urandom_range(0, 5);
    rel = 4'($urandom);
    if (pick == 2) rel[b] = 1'b0;
    send_item(KIND_TICK, 2'($urandom), sim_ms, rel);
    case (pick)
      0: begin
        sim_ms += window_cfg + 1 + $urandom_range(0, 30);
        send_item(KIND_TICK, 2'($urandom), sim_ms, 4'($urandom));
      end
      1: begin
        sim_ms += debounce_cfg + 1 + $urandom_range(0, 10);
        send_item(KIND_EDGE, b, sim_ms, 4'($urandom));
        sim_ms += $urandom_range(0, 3);
        send_item(KIND_TICK, 2'($urandom), sim_ms, 4'($urandom));
      end
      2: begin
        sim_ms += window_cfg + 1 + $urandom_range(0, 30);
        send_item(KIND_TICK, 2'($urandom), sim_ms, rel);
        send_item(KIND_QUERY, b, sim_ms, 4'($urandom));
        sim_ms += $urandom_range(0, 400);
        rel[b] = 1'b1;
        send_item(KIND_TICK, 2'($urandom), sim_ms, rel);
      end
      default: begin
        // land right on the window boundary
        sim_ms += window_cfg + $urandom_range(0, 1);
        send_item(KIND_TICK, 2'($urandom), sim_ms, 4'($urandom));
      end
    endcase
    if ($urandom_range(0, 4) != 0) send_item(KIND_QUERY, b, sim_ms, 4'($urandom));
  endtask

  task automatic noise_item();
    logic [31:0] now_ms;
    if ($urandom_range(0, 1) == 0) now_ms = $urandom;
    else now_ms = sim_ms + $urandom_range(0, 1000);
    if ($urandom_range(0, 7) == 0) sim_ms = now_ms;
    send_item(2'($urandom), 2'($urandom), now_ms, 4'($urandom));
  endtask

  task automatic run_random(input int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(0, 9) < 7) click_sequence();
      else noise_item();
    end
  endtask

  task automatic test_random_settings();
    write_reg(CFG_DEBOUNCE, 16'd50);
    write_reg(CFG_DOUBLE, 16'd300);
    run_random(200);
    write_reg(CFG_DEBOUNCE, 16'd0);
    write_reg(CFG_DOUBLE, 16'd0);
    run_random(150);
    write_reg(CFG_DEBOUNCE, 16'hFFFF);
    write_reg(CFG_DOUBLE, 16'hFFFF);
    run_random(150);
    write_reg(CFG_DEBOUNCE, 16'($urandom_range(0, 200)));
    write_reg(CFG_DOUBLE, 16'($urandom_range(200, 3000)));
    run_random(200);
  endtask

  task automatic test_backpressure();
    int start;
    drain();
    idle_on      = 1'b0;
    hold_off_req = 1'b1;
    start        = items_sent;
    while (items_sent - start < 40) click_sequence();
    drain();
    idle_on = 1'b1;
  endtask

  task automatic test_steady_stream();
    write_reg(CFG_DEBOUNCE, 16'($urandom));
    write_reg(CFG_DOUBLE, 16'($urandom));
    idle_on = 1'b0;
    run_random(200);
  endtask

  initial begin
    int wait_cycles;
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_DEBOUNCE;
    cfg_data     = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = KIND_EDGE;
    idle_on      = 1'b1;
    hold_off_req = 1'b0;
    error_count  = 0;
    items_sent   = 0;
    debounce_cfg = 16'd50;
    window_cfg   = 16'd300;
    last_edge_ms = '0;
    sim_ms       = '0;
    clear_buttons();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_click_kinds();
    test_register_extremes();
    test_random_settings();
    test_backpressure();
    test_steady_stream();

    in_tvalid   = 1'b0;
    wait_cycles = 0;
    while (expected_events.size() != 0 && wait_cycles < 5000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (20) @(negedge clk);
    if (expected_events.size() != 0) begin
      $error("%0d expected results never arrived", expected_events.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
